// ===== src/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared constants, status codes and controller/datapath interface types for
// the five-point derivative block.
// ----------------------------------------------------------------------------
package fpd_pkg;

  // Channel and window geometry
  localparam int NUM_JOINTS = 8;
  localparam int HIST       = 4;   // stored samples per joint
  localparam int HALF       = 2;   // centre offset from newest sample
  localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int HIDX_W     = $clog2(HIST);
  localparam int FILL_W     = 3;

  // Field widths
  localparam int JOINT_W = 3;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int OUT_W   = 48;
  localparam int AVG_W   = 30;
  localparam int STAT_W  = 2;

  // Arithmetic widths
  localparam int N_W    = 39;  // signed stencil sums
  localparam int MAG1_W = 36;  // |num1|
  localparam int MAG2_W = 38;  // |num2|
  localparam int M1_W   = 56;  // |num1| * 1e6
  localparam int M2A_W  = 60;  // |num2| * 4e6
  localparam int SQ_W   = 64;  // S * S
  localparam int DVS1_W = 34;  // 3 * S
  localparam int DVD_W  = 80;  // widest dividend
  localparam int DVS_W  = 66;  // widest divisor
  localparam int Q_W    = 48;  // quotient bits developed
  localparam int CNT_W  = $clog2(Q_W + 1);

  // Scale factors
  localparam logic [19:0] VEL_SCALE = 20'd1000000;
  localparam logic [21:0] ACC_PRE   = 22'd4000000;

  // Saturation limits
  localparam logic [OUT_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_NOT_FULL = 2'd0;
  localparam logic [STAT_W-1:0] ST_JITTER   = 2'd1;
  localparam logic [STAT_W-1:0] ST_VALID    = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic mul1;
    logic mul2;
    logic div_start;
    logic load_out;
  } fpd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic joint_ok;
    logic need_div;
    logic div_done;
  } fpd_stat_t;

endpackage

// ===== src/fpd_div.sv =====
// ----------------------------------------------------------------------------
// fpd_div
// Restoring divider, one quotient bit per cycle. Flags a quotient that does
// not fit in Q_W bits.
// ----------------------------------------------------------------------------
module fpd_div import fpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic             sat_o,
  output logic [Q_W-1:0]   quot_o
);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [Q_W-1:0]   low_q;
  logic             sat_q;
  logic [DVS_W:0]   shifted;
  logic             ge;
  logic [DVS_W-1:0] rem_top;

  // upper dividend bits seed the remainder
  assign rem_top = DVS_W'(dividend_i[DVD_W-1:Q_W]);
  assign shifted = {rem_q, low_q[Q_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(Q_W);
    end else if (busy_q) begin
      busy_q <= (cnt_q != CNT_W'(1));
      cnt_q  <= cnt_q - CNT_W'(1);
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_top;
      low_q <= dividend_i[Q_W-1:0];
      dvs_q <= divisor_i;
      sat_q <= rem_top >= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DVS_W'(shifted - {1'b0, dvs_q}) : DVS_W'(shifted);
      low_q <= {low_q[Q_W-2:0], ge};
    end
  end

  assign done_o = !busy_q;
  assign sat_o  = sat_q;
  assign quot_o = low_q;

endmodule

// ===== src/fpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpd_ctrl
// Sequencer: capture, evaluate window, multiply and divide when needed, hand off result.
// ----------------------------------------------------------------------------
module fpd_ctrl import fpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fpd_cmd_t  cmd_o,
  input  fpd_stat_t stat_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_MUL1  = 7'b0000100,
    S_MUL2  = 7'b0001000,
    S_START = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } fpd_state_e;

  fpd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval      = (state_q == S_EVAL) && stat_i.joint_ok;
    cmd_o.mul1      = (state_q == S_MUL1);
    cmd_o.mul2      = (state_q == S_MUL2);
    cmd_o.div_start = (state_q == S_START);
    cmd_o.load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!stat_i.joint_ok)     state_d = S_IDLE;
        else if (stat_i.need_div) state_d = S_MUL1;
        else                      state_d = S_DONE;
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (stat_i.div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (cmd_o.load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load_out)              out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/fpd_dp.sv =====
// ----------------------------------------------------------------------------
// fpd_dp
// Datapath: per-joint sample windows, stencil sums, jitter check, scaling
// multipliers, two dividers and the output register.
// ----------------------------------------------------------------------------
module fpd_dp import fpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fpd_cmd_t                 cmd_i,
  output fpd_stat_t                stat_o,
  input  logic [JOINT_W-1:0]       joint_index_i,
  input  logic [TIME_W-1:0]        sample_time_us_i,
  input  logic signed [POS_W-1:0]  position_i,
  output logic [JOINT_W-1:0]       out_joint_o,
  output logic signed [POS_W-1:0]  centre_position_o,
  output logic signed [OUT_W-1:0]  velocity_o,
  output logic signed [OUT_W-1:0]  acceleration_o,
  output logic [AVG_W-1:0]         avg_period_us_o
  ,
  output logic [STAT_W-1:0]        status_o
);

  // captured item
  logic [JOINT_W-1:0] joint_q;
  logic [TIME_W-1:0]  tin_q;
  logic [POS_W-1:0]   pin_q;

  // window storage
  logic [POS_W-1:0]  pos_q  [NUM_JOINTS][HIST];
  logic [TIME_W-1:0] time_q [NUM_JOINTS][HIST];
  logic [FILL_W-1:0] fill_q [NUM_JOINTS];

  // evaluation results
  logic [STAT_W-1:0] status_q;
  logic [POS_W-1:0]  cpos_q;
  logic [AVG_W-1:0]  avg_q;
  logic [TIME_W-1:0] span_q;
  logic [MAG1_W-1:0] mag1_q;
  logic [MAG2_W-1:0] mag2_q;
  logic              neg1_q, neg2_q;

  // multiplier stages
  logic [M1_W-1:0]   m1_q;
  logic [M2A_W-1:0]  m2a_q;
  logic [SQ_W-1:0]   sq_q;
  logic [DVD_W-1:0]  dvd2_q;
  logic [DVS1_W-1:0] dvs1_q;
  logic [DVS_W-1:0]  dvs2_q;

  logic              joint_ok;
  logic [JIDX_W-1:0] jidx;
  logic [FILL_W-1:0] fill;
  logic              full;
  logic [TIME_W-1:0] tw [HIST+1];
  logic [TIME_W-1:0] span;
  logic              jit;
  logic [TIME_W-1:0] dt;
  logic signed [35:0] diff;
  logic [35:0]       adiff;
  logic [39:0]       tenx;
  logic signed [N_W-1:0] p [HIST+1];
  logic signed [N_W-1:0] n1, n2;
  logic [N_W-1:0]    a1, a2;
  logic [POS_W-1:0]  cpos;
  logic [HIDX_W-1:0] cidx;

  logic             v_done, a_done, v_sat, a_sat;
  logic [Q_W-1:0]   v_quot, a_quot;

  // saturate a quotient magnitude to the signed output range
  function automatic logic [OUT_W-1:0] sat_apply(input logic neg, input logic sat,
                                                 input logic [Q_W-1:0] q);
    logic [OUT_W-1:0] r;
    if (neg) begin
      if (sat || q > NEG_LIMIT) r = NEG_LIMIT;
      else                      r = OUT_W'(-q);
    end else begin
      if (sat || q > POS_LIMIT) r = POS_LIMIT;
      else                      r = q;
    end
    return r;
  endfunction

  // capture accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      joint_q <= joint_index_i;
      tin_q   <= sample_time_us_i;
      pin_q   <= position_i;
    end
  end

  assign joint_ok = int'(joint_q) < NUM_JOINTS;
  assign jidx     = JIDX_W'(joint_q);
  assign fill     = fill_q[jidx];
  assign full     = fill >= FILL_W'(HIST);

  // window row, newest sample last
  always_comb begin
    for (int k = 0; k < HIST; k++) begin
      tw[k] = time_q[jidx][k];
      p[k]  = N_W'($signed(pos_q[jidx][k]));
    end
    tw[HIST] = tin_q;
    p[HIST]  = N_W'($signed(pin_q));
  end

  assign span = tw[HIST] - tw[0];

  // interval check: reject when 10*|4*dt - S| > S
  always_comb begin
    jit   = 1'b0;
    dt    = '0;
    diff  = '0;
    adiff = '0;
    tenx  = '0;
    for (int k = 0; k < HIST; k++) begin
      dt    = tw[k+1] - tw[k];
      diff  = $signed({2'b00, dt, 2'b00}) - $signed({4'b0000, span});
      adiff = diff[35] ? 36'(-diff) : 36'(diff);
      tenx  = {adiff, 3'b000} + {3'b000, adiff, 1'b0};
      if (tenx > {8'd0, span}) jit = 1'b1;
    end
  end

  // stencil sums
  assign n1 = p[0] - (p[1] <<< 3) + (p[3] <<< 3) - p[4];
  assign n2 = (p[1] <<< 4) + (p[3] <<< 4) - p[0] - p[4]
            - (p[2] <<< 5) + (p[2] <<< 1);
  assign a1 = n1[N_W-1] ? N_W'(-n1) : N_W'(n1);
  assign a2 = n2[N_W-1] ? N_W'(-n2) : N_W'(n2);

  // centre sample
  assign cidx = HIDX_W'(fill - FILL_W'(HALF));
  always_comb begin
    if (full)                      cpos = pos_q[jidx][HALF];
    else if (fill >= FILL_W'(HALF)) cpos = pos_q[jidx][cidx];
    else                           cpos = '0;
  end

  assign stat_o.joint_ok = joint_ok;
  assign stat_o.need_div = full && (span != '0) && !jit;
  assign stat_o.div_done = v_done && a_done;

  // fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_JOINTS; j++) fill_q[j] <= '0;
    end else if (cmd_i.eval && !full) begin
      fill_q[jidx] <= fill + FILL_W'(1);
    end
  end

  // window update: append while filling, shift once full
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      if (!full) begin
        pos_q[jidx][fill[HIDX_W-1:0]]  <= pin_q;
        time_q[jidx][fill[HIDX_W-1:0]] <= tin_q;
      end else begin
        for (int k = 0; k < HIST - 1; k++) begin
          pos_q[jidx][k]  <= pos_q[jidx][k+1];
          time_q[jidx][k] <= time_q[jidx][k+1];
        end
        pos_q[jidx][HIST-1]  <= pin_q;
        time_q[jidx][HIST-1] <= tin_q;
      end
    end
  end

  // evaluation register
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      cpos_q <= cpos;
      span_q <= span;
      avg_q  <= full ? AVG_W'(span >> 2) : '0;
      mag1_q <= MAG1_W'(a1);
      mag2_q <= MAG2_W'(a2);
      neg1_q <= n1[N_W-1];
      neg2_q <= n2[N_W-1];
      if (!full)                       status_q <= ST_NOT_FULL;
      else if ((span == '0) || jit)    status_q <= ST_JITTER;
      else                             status_q <= ST_VALID;
    end
  end

  // scaling products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      m1_q  <= M1_W'(mag1_q * VEL_SCALE);
      m2a_q <= M2A_W'(mag2_q * ACC_PRE);
      sq_q  <= SQ_W'(span_q * span_q);
    end
    if (cmd_i.mul2) begin
      dvd2_q <= DVD_W'(m2a_q * VEL_SCALE);
      dvs1_q <= {1'b0, span_q, 1'b0} + {2'b00, span_q};
      dvs2_q <= {1'b0, sq_q, 1'b0} + {2'b00, sq_q};
    end
  end

  // velocity: |num1|*1e6 / (3S)
  fpd_div u_vel_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (DVD_W'(m1_q)),
    .divisor_i  (DVS_W'(dvs1_q)),
    .done_o     (v_done),
    .sat_o      (v_sat),
    .quot_o     (v_quot)
  );

  // acceleration: |num2|*4e12 / (3S^2)
  fpd_div u_acc_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd2_q),
    .divisor_i  (dvs2_q),
    .done_o     (a_done),
    .sat_o      (a_sat),
    .quot_o     (a_quot)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_joint_o       <= joint_q;
      centre_position_o <= cpos_q;
      avg_period_us_o   <= avg_q;
      status_o          <= status_q;
      if (status_q == ST_VALID) begin
        velocity_o     <= sat_apply(neg1_q, v_sat, v_quot);
        acceleration_o <= sat_apply(neg2_q, a_sat, a_quot);
      end else begin
        velocity_o     <= '0;
        acceleration_o <= '0;
      end
    end
  end

endmodule

// ===== src/five_point_derivative_with_jitter_check.sv =====
// An accepted item is captured and its window evaluated; a result whose
// window is not full, or whose timing fails, then goes to the output
// register, while a valid result first passes the multiply steps and the
// bit-serial divide. One item at a time; a finished result waits in the
// output register while the next item is taken. Reset clears all fill
// counts and the output valid; window contents need no clearing.
// ----------------------------------------------------------------------------
// five_point_derivative_with_jitter_check
// Per-joint five-point central-difference velocity and acceleration with a
// sample interval regularity check.
// ----------------------------------------------------------------------------
module five_point_derivative_with_jitter_check import fpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [JOINT_W-1:0]      joint_index_i,
  input  logic [TIME_W-1:0]       sample_time_us_i,
  input  logic signed [POS_W-1:0] position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [JOINT_W-1:0]      out_joint_o,
  output logic signed [POS_W-1:0] centre_position_o,
  output logic signed [OUT_W-1:0] velocity_o,
  output logic signed [OUT_W-1:0] acceleration_o,
  output logic [AVG_W-1:0]        avg_period_us_o,
  output logic [STAT_W-1:0]       status_o
);

  fpd_cmd_t  cmd;
  fpd_stat_t stat;

  // sequencer
  fpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // arithmetic and storage
  fpd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .joint_index_i     (joint_index_i),
    .sample_time_us_i  (sample_time_us_i),
    .position_i        (position_i),
    .out_joint_o       (out_joint_o),
    .centre_position_o (centre_position_o),
    .velocity_o        (velocity_o),
    .acceleration_o    (acceleration_o),
    .avg_period_us_o   (avg_period_us_o),
    .status_o          (status_o)
  );

endmodule
